/* hdl/utf8_stream_decoder_unit_assert.svh */
// assertion macros for the utf8 stream decoder checker
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define U8SD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8sd assertion failed");

// next-cycle implication
`define U8SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8sd assertion failed");

`endif

/* hdl/u8sd_pkg.sv */
// ----------------------------------------------------------------------------
// u8sd_pkg
// shared types and constants of the utf8 stream decoder
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam int CP_W = 21;

  typedef enum logic [2:0] {
    CLS_ASCII = 3'd0,
    CLS_LEAD2 = 3'd1,
    CLS_LEAD3 = 3'd2,
    CLS_LEAD4 = 3'd3,
    CLS_CONT  = 3'd4,
    CLS_BAD   = 3'd5
  } byte_class_t;

  typedef struct packed {
    byte_class_t cls;
    logic [6:0]  bits;
  } byte_entry_t;

endpackage

/* hdl/u8sd_front.sv */
// ----------------------------------------------------------------------------
// u8sd_front
// classifies each incoming byte and extracts its payload bits
// ----------------------------------------------------------------------------
module u8sd_front (
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  output logic                 push_valid,
  output u8sd_pkg::byte_entry_t push_entry
);
  import u8sd_pkg::*;

  assign push_valid = in_valid;

  always_comb begin
    push_entry.cls  = CLS_BAD;
    push_entry.bits = 7'd0;
    if (!in_byte[7]) begin
      push_entry.cls  = CLS_ASCII;
      push_entry.bits = in_byte[6:0];
    end else if (in_byte[7:5] == 3'b110) begin
      push_entry.cls  = CLS_LEAD2;
      push_entry.bits = {2'b00, in_byte[4:0]};
    end else if (in_byte[7:4] == 4'b1110) begin
      push_entry.cls  = CLS_LEAD3;
      push_entry.bits = {3'b000, in_byte[3:0]};
    end else if (in_byte[7:3] == 5'b11110) begin
      push_entry.cls  = CLS_LEAD4;
      push_entry.bits = {4'b0000, in_byte[2:0]};
    end else if (in_byte[7:6] == 2'b10) begin
      push_entry.cls  = CLS_CONT;
      push_entry.bits = {1'b0, in_byte[5:0]};
    end
  end

endmodule

/* hdl/u8sd_queue.sv */
// ----------------------------------------------------------------------------
// u8sd_queue
// short fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
module u8sd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  input  u8sd_pkg::byte_entry_t push_entry,
  output logic                  push_full,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output u8sd_pkg::byte_entry_t pop_entry
);
  import u8sd_pkg::*;

  byte_entry_t           entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign push_full = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_entry = entries[rd_ptr];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

endmodule

/* hdl/u8sd_back.sv */
// ----------------------------------------------------------------------------
// u8sd_back
// sequence state, completion checks and the registered result
// ----------------------------------------------------------------------------
module u8sd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  u8sd_pkg::byte_entry_t pop_entry,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  has_code_point,
  output logic [20:0]           code_point,
  output logic                  decode_error,
  output logic                  replay_byte,
  output logic                  now_idle
);
  import u8sd_pkg::*;

  localparam logic [2:0] SEQ_LEN_2 = 3'd2;
  localparam logic [2:0] SEQ_LEN_3 = 3'd3;
  localparam logic [2:0] SEQ_LEN_4 = 3'd4;

  logic [CP_W-1:0] partial_value, partial_value_next;
  logic [1:0]      bytes_pending, bytes_pending_next;
  logic [2:0]      sequence_length, sequence_length_next;
  logic            has_next, err_next, rep_next;
  logic [CP_W-1:0] cp_next;
  logic [CP_W-1:0] shifted;
  logic            do_pop;

  function automatic logic value_bad(input logic [CP_W-1:0] v, input logic [2:0] len);
    logic overlong;
    overlong = 1'b0;
    if (len == SEQ_LEN_2) overlong = (v < CP_W'(32'h80));
    else if (len == SEQ_LEN_3) overlong = (v < CP_W'(32'h800));
    else if (len == SEQ_LEN_4) overlong = (v < CP_W'(32'h10000));
    return overlong || (v > CP_W'(32'h10FFFF)) ||
           ((v >= CP_W'(32'hD800)) && (v <= CP_W'(32'hDFFF)));
  endfunction

  assign pop_ready = !out_valid || !out_stall;
  assign do_pop    = pop_valid && pop_ready;
  assign shifted   = {partial_value[CP_W-7:0], pop_entry.bits[5:0]};

  always_comb begin
    partial_value_next   = partial_value;
    bytes_pending_next   = bytes_pending;
    sequence_length_next = sequence_length;
    has_next = 1'b0;
    err_next = 1'b0;
    rep_next = 1'b0;
    cp_next  = '0;
    if (bytes_pending == 2'd0) begin
      sequence_length_next = 3'd0;
      unique case (pop_entry.cls)
        CLS_ASCII: begin
          has_next = 1'b1;
          cp_next  = CP_W'(pop_entry.bits);
        end
        CLS_LEAD2: begin
          partial_value_next   = CP_W'(pop_entry.bits[4:0]);
          bytes_pending_next   = 2'd1;
          sequence_length_next = SEQ_LEN_2;
        end
        CLS_LEAD3: begin
          partial_value_next   = CP_W'(pop_entry.bits[3:0]);
          bytes_pending_next   = 2'd2;
          sequence_length_next = SEQ_LEN_3;
        end
        CLS_LEAD4: begin
          partial_value_next   = CP_W'(pop_entry.bits[2:0]);
          bytes_pending_next   = 2'd3;
          sequence_length_next = SEQ_LEN_4;
        end
        default: begin
          err_next           = 1'b1;
          partial_value_next = '0;
          bytes_pending_next = 2'd0;
        end
      endcase
    end else if (pop_entry.cls == CLS_CONT) begin
      partial_value_next = shifted;
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending == 2'd1) begin
        sequence_length_next = 3'd0;
        partial_value_next   = '0;
        if (value_bad(shifted, sequence_length)) begin
          err_next = 1'b1;
        end else begin
          has_next = 1'b1;
          cp_next  = shifted;
        end
      end
    end else begin
      err_next             = 1'b1;
      rep_next             = 1'b1;
      partial_value_next   = '0;
      bytes_pending_next   = 2'd0;
      sequence_length_next = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_pending   <= 2'd0;
      sequence_length <= 3'd0;
      out_valid       <= 1'b0;
    end else begin
      if (do_pop) begin
        partial_value   <= partial_value_next;
        bytes_pending   <= bytes_pending_next;
        sequence_length <= sequence_length_next;
      end
      if (pop_ready) begin
        out_valid <= do_pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      has_code_point <= has_next;
      code_point     <= cp_next;
      decode_error   <= err_next;
      replay_byte    <= rep_next;
      now_idle       <= (bytes_pending_next == 2'd0);
    end
  end

endmodule

/* hdl/utf8_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// incremental utf-8 decoder, one byte in and one result out per transaction
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------
//   input    | in        | in_valid / in_stall  | in_byte
//   output   | out       | out_valid / out_stall| has_code_point, code_point,
//            |           |                      | decode_error, replay_byte,
//            |           |                      | now_idle
//
// one byte per cycle sustained while in_stall is low; the back-end sequence
// state updates once per byte. bytes are registered in a four-entry queue that
// keeps taking them while the output stalls, and results in the back end.
// synchronous reset clears the queue, the sequence state and the output valid.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        has_code_point,
  output logic [20:0] code_point,
  output logic        decode_error,
  output logic        replay_byte,
  output logic        now_idle
);
  import u8sd_pkg::*;

  logic        push_valid;
  byte_entry_t push_entry;
  logic        push_full;
  logic        pop_valid;
  logic        pop_ready;
  byte_entry_t pop_entry;

  assign in_stall = push_full;

  u8sd_front u_front (
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  u8sd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_full  (push_full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  u8sd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_entry      (pop_entry),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .has_code_point (has_code_point),
    .code_point     (code_point),
    .decode_error   (decode_error),
    .replay_byte    (replay_byte),
    .now_idle       (now_idle)
  );

endmodule

/* hdl/u8sd_checker.sv */
// ----------------------------------------------------------------------------
// u8sd_checker
// port-level checks of the utf8 stream decoder
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_unit_assert.svh"

module u8sd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        has_code_point,
  input logic [20:0] code_point,
  input logic        decode_error,
  input logic        replay_byte,
  input logic        now_idle
);

  // stalled result transaction holds
  `U8SD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(code_point) && $stable(decode_error))

  // a code point and an error never come together
  `U8SD_ASSERT_NOW(a_has_xor_err, clk, rst, out_valid && has_code_point, !decode_error)

  // replay only with an error, and the decoder is then idle
  `U8SD_ASSERT_NOW(a_replay_err, clk, rst, out_valid && replay_byte, decode_error && now_idle)

  // code point reads zero without a valid value
  `U8SD_ASSERT_NOW(a_cp_zero, clk, rst, out_valid && !has_code_point, code_point == 21'd0)

  // input held off only while a result is waiting
  `U8SD_ASSERT_NOW(a_full_backed, clk, rst, in_stall, out_valid)

endmodule

bind utf8_stream_decoder_unit u8sd_checker u_u8sd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .has_code_point (has_code_point),
  .code_point     (code_point),
  .decode_error   (decode_error),
  .replay_byte    (replay_byte),
  .now_idle       (now_idle)
);

/* dv/utf8_decode_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_decode_checker
// watches both channels of the utf-8 stream decoder, decodes every accepted
// byte on its own and compares each accepted result, field by field, with the
// oldest decoded value still waiting
// ----------------------------------------------------------------------------
module utf8_decode_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        has_code_point,
  input  logic [20:0] code_point,
  input  logic        decode_error,
  input  logic        replay_byte,
  input  logic        now_idle,
  output int          fail_count,
  output int          pending
);
  import u8sd_pkg::*;

  localparam logic [CP_W-1:0] MAX_SCALAR  = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_2BYTE   = 21'h000080;
  localparam logic [CP_W-1:0] MIN_3BYTE   = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4BYTE   = 21'h010000;

  typedef struct packed {
    logic            has;
    logic [CP_W-1:0] cp;
    logic            err;
    logic            rep;
    logic            idle;
  } decode_result_t;

  logic [CP_W-1:0] seq_value;
  logic [1:0]      cont_left;
  logic [2:0]      seq_len;
  decode_result_t  decoded_q [$];
  int              mismatches;

  initial begin
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
    seq_value  = '0;
    cont_left  = '0;
    seq_len    = '0;
  end

  task automatic clear_seq();
    seq_value = '0;
    cont_left = '0;
    seq_len   = '0;
  endtask

  task automatic advance_decoder(input logic [7:0] b, output decode_result_t r);
    logic [CP_W-1:0] v;
    logic [2:0]      len;
    logic            bad;
    r = '0;
    if (cont_left == 2'd0) begin
      seq_len = 3'd0;
      if (b < 8'h80) begin
        r.has = 1'b1;
        r.cp  = {13'd0, b};
      end else if ((b & 8'hE0) == 8'hC0) begin
        seq_value = {16'd0, b[4:0]};
        cont_left = 2'd1;
        seq_len   = 3'd2;
      end else if ((b & 8'hF0) == 8'hE0) begin
        seq_value = {17'd0, b[3:0]};
        cont_left = 2'd2;
        seq_len   = 3'd3;
      end else if ((b & 8'hF8) == 8'hF0) begin
        seq_value = {18'd0, b[2:0]};
        cont_left = 2'd3;
        seq_len   = 3'd4;
      end else begin
        r.err = 1'b1;
        clear_seq();
      end
    end else if (b[7:6] == 2'b10) begin
      seq_value = {seq_value[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        v       = seq_value;
        len     = seq_len;
        seq_len = 3'd0;
        bad = (len == 3'd2 && v < MIN_2BYTE) || (len == 3'd3 && v < MIN_3BYTE) ||
              (len == 3'd4 && v < MIN_4BYTE) || (v > MAX_SCALAR) ||
              (v >= SURR_LO && v <= SURR_HI);
        if (bad) begin
          r.err = 1'b1;
          clear_seq();
        end else begin
          r.has     = 1'b1;
          r.cp      = v;
          seq_value = '0;
        end
      end
    end else begin
      r.err = 1'b1;
      r.rep = 1'b1;
      clear_seq();
    end
    r.idle = (cont_left == 2'd0);
  endtask

  task automatic check_field(input string name, input logic [CP_W-1:0] exp_v,
                             input logic [CP_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    decode_result_t want;
    decode_result_t next_r;
    if (rst) begin
      clear_seq();
      decoded_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("result transaction with no decoded byte waiting");
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("has_code_point", CP_W'(want.has), CP_W'(has_code_point));
          check_field("code_point", want.cp, code_point);
          check_field("decode_error", CP_W'(want.err), CP_W'(decode_error));
          check_field("replay_byte", CP_W'(want.rep), CP_W'(replay_byte));
          check_field("now_idle", CP_W'(want.idle), CP_W'(now_idle));
        end
      end
      if (in_valid && !in_stall) begin
        advance_decoder(in_byte, next_r);
        decoded_q.push_back(next_r);
      end
    end
    fail_count <= mismatches;
    pending    <= decoded_q.size();
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives a byte stream into the utf-8 stream decoder: a directed opening with
// boundary bytes, error cases and an interrupted sequence, then mostly
// well-formed random sequences mixed with noise and broken sequences, with
// random idling on both sides and one long output hold-off
// ----------------------------------------------------------------------------
module tb;

  localparam int ITEMS    = 1650;
  localparam int QUIET_AT = ITEMS - 150;
  localparam int HOLD_AT  = 500;
  localparam int LIMIT    = 400000;

  localparam logic [7:0] DIRECTED [26] = '{
    8'h00, 8'h7F, 8'h80, 8'hF8, 8'hFF,
    8'hC2, 8'hA9,
    8'hC1, 8'hBF,
    8'hE2, 8'h82, 8'hAC,
    8'hED, 8'hA0, 8'h80,
    8'hF4, 8'h8F, 8'hBF, 8'hBF,
    8'hF5, 8'h80, 8'h80, 8'h80,
    8'hE0, 8'h41, 8'h41
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic        has_code_point;
  logic [20:0] code_point;
  logic        decode_error;
  logic        replay_byte;
  logic        now_idle;

  int fail_count;
  int pending;
  int cycles    = 0;
  int sent_cnt  = 0;
  int gap_pct   = 20;
  bit quiet     = 1'b0;

  always #6 clk = ~clk;

  utf8_stream_decoder_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .has_code_point (has_code_point),
    .code_point     (code_point),
    .decode_error   (decode_error),
    .replay_byte    (replay_byte),
    .now_idle       (now_idle)
  );

  utf8_decode_checker chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .has_code_point (has_code_point),
    .code_point     (code_point),
    .decode_error   (decode_error),
    .replay_byte    (replay_byte),
    .now_idle       (now_idle),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("utf8_stream_decoder_unit test failed");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_cnt++;
    if (sent_cnt >= QUIET_AT) quiet = 1'b1;
  endtask

  task automatic send_cont();
    send_byte(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  function automatic int conts_for(input logic [7:0] b);
    if ((b & 8'hE0) == 8'hC0) return 1;
    if ((b & 8'hF0) == 8'hE0) return 2;
    if ((b & 8'hF8) == 8'hF0) return 3;
    return 0;
  endfunction

  function automatic logic [7:0] random_lead(input int n);
    case (n)
      2:       return 8'hC0 | 8'($urandom_range(0, 31));
      3:       return 8'hE0 | 8'($urandom_range(0, 15));
      default: return 8'hF0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic send_scalar(input logic [20:0] v);
    if (v < 21'h80) begin
      send_byte(v[7:0]);
    end else if (v < 21'h800) begin
      send_byte({3'b110, v[10:6]});
      send_byte({2'b10, v[5:0]});
    end else if (v < 21'h10000) begin
      send_byte({4'b1110, v[15:12]});
      send_byte({2'b10, v[11:6]});
      send_byte({2'b10, v[5:0]});
    end else begin
      send_byte({5'b11110, v[20:18]});
      send_byte({2'b10, v[17:12]});
      send_byte({2'b10, v[11:6]});
      send_byte({2'b10, v[5:0]});
    end
  endtask

  // output side: random stall bursts, one long hold-off, none at the end
  initial begin : receiver
    int  burst;
    int  hold;
    int  stall_pct;
    int  tick;
    bit  held;
    out_stall = 1'b0;
    burst     = 0;
    hold      = 0;
    stall_pct = 20;
    tick      = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (tick % 150 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      if (!held && sent_cnt >= HOLD_AT) begin
        held = 1'b1;
        hold = 90;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        burst = $urandom_range(0, 10);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int          pick;
    int          n;
    int          k;
    int          next_shuffle;
    logic [20:0] v;
    logic [7:0]  b;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_byte  = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < 26; i++) send_byte(DIRECTED[i]);

    next_shuffle = sent_cnt;
    while (sent_cnt < ITEMS) begin
      if (sent_cnt >= next_shuffle) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          default: gap_pct = 35;
        endcase
        next_shuffle = sent_cnt + 100;
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_byte(8'($urandom_range(0, 127)));
      end else if (pick < 50) begin
        case ($urandom_range(1, 4))
          1: v = 21'($urandom_range(0, 21'h7F));
          2: v = 21'($urandom_range(21'h80, 21'h7FF));
          3: begin
            v = 21'($urandom_range(21'h800, 21'hFFFF));
            if (v >= 21'hD800 && v <= 21'hDFFF) v = v ^ 21'h2000;
          end
          default: v = 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        send_scalar(v);
      end else if (pick < 75) begin
        n = $urandom_range(2, 4);
        send_byte(random_lead(n));
        repeat (n - 1) send_cont();
      end else if (pick < 88) begin
        n = $urandom_range(2, 4);
        send_byte(random_lead(n));
        k = $urandom_range(0, n - 2);
        repeat (k) send_cont();
        b = 8'($urandom_range(0, 255));
        while (b[7:6] == 2'b10) b = 8'($urandom_range(0, 255));
        send_byte(b);
        send_byte(b);
        repeat (conts_for(b)) send_cont();
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("utf8_stream_decoder_unit test passed");
    end else begin
      $display("utf8_stream_decoder_unit test failed");
    end
    $finish;
  end

endmodule
